>>> rtl/core/aad_pkg.sv
// ----------------------------------------------------------------------------
// aad_pkg
// Shared types and constants for the area-average downscaler.
// ----------------------------------------------------------------------------
package aad_pkg;

  localparam int unsigned CFG_W    = 13;  // configuration register width
  localparam int unsigned CFG_IDX_W = 2;  // register index width
  localparam int unsigned PIX_W    = 8;   // one colour channel
  localparam int unsigned CH_N     = 4;   // red, green, blue, alpha
  localparam int unsigned SUM_W    = 32;  // per-column channel sum
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGE   = 2'd2;

  // Commands from the controller to the datapath
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_GEO_DIRECT,
    CMD_DIV_OW,
    CMD_SET_OW,
    CMD_DIV_OH,
    CMD_SET_OH,
    CMD_WRAP,
    CMD_DIV_CBE0,
    CMD_SET_CBE0,
    CMD_DIV_RBE0,
    CMD_SET_RBE0,
    CMD_READ,
    CMD_ACC,
    CMD_DIV_MEAN,
    CMD_SET_MEAN,
    CMD_EMIT,
    CMD_ADVANCE,
    CMD_DIV_RBE,
    CMD_SET_RBE,
    CMD_DIV_CBE,
    CMD_SET_CBE
  } aad_cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GEO_DIR,
    ST_OW_GO,
    ST_OW_WT,
    ST_OH_GO,
    ST_OH_WT,
    ST_WRAP,
    ST_FRAME,
    ST_CBE0_WT,
    ST_RBE0_GO,
    ST_RBE0_WT,
    ST_READ,
    ST_ACC,
    ST_MEAN_GO,
    ST_MEAN_WT,
    ST_EMIT,
    ST_ADV,
    ST_RBE_GO,
    ST_RBE_WT,
    ST_CBE_GO,
    ST_CBE_WT
  } aad_state_e;

  // Status from the datapath to the controller
  typedef struct packed {
    logic geo_valid;
    logic pass_thru;
    logic col_zero;
    logic row_zero;
    logic box_done;
    logic ch_last;
    logic out_full;
    logic need_rbe;
    logic need_cbe;
    logic div_done;
  } aad_status_t;

endpackage

>>> rtl/core/aad_div.sv
// ----------------------------------------------------------------------------
// aad_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aad_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  // One restoring step
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/core/aad_ctrl.sv
// ----------------------------------------------------------------------------
// aad_ctrl
// Sequencer for one source pixel: geometry, box set-up, accumulate, mean, step.
// ----------------------------------------------------------------------------
module aad_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  aad_pkg::aad_status_t stat_i,
  output aad_pkg::aad_cmd_e    cmd_o
);
  import aad_pkg::*;

  aad_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.geo_valid) state_d = ST_WRAP;
          else if (stat_i.pass_thru) state_d = ST_GEO_DIR;
          else state_d = ST_OW_GO;
        end
      end
      ST_GEO_DIR: state_d = ST_WRAP;
      ST_OW_GO:   state_d = ST_OW_WT;
      ST_OW_WT:   if (stat_i.div_done) state_d = ST_OH_GO;
      ST_OH_GO:   state_d = ST_OH_WT;
      ST_OH_WT:   if (stat_i.div_done) state_d = ST_WRAP;
      ST_WRAP:    state_d = ST_FRAME;
      ST_FRAME:   state_d = stat_i.col_zero ? ST_CBE0_WT : ST_READ;
      ST_CBE0_WT: begin
        if (stat_i.div_done) state_d = stat_i.row_zero ? ST_RBE0_GO : ST_READ;
      end
      ST_RBE0_GO: state_d = ST_RBE0_WT;
      ST_RBE0_WT: if (stat_i.div_done) state_d = ST_READ;
      ST_READ:    state_d = ST_ACC;
      ST_ACC:     state_d = stat_i.box_done ? ST_MEAN_GO : ST_ADV;
      ST_MEAN_GO: state_d = ST_MEAN_WT;
      ST_MEAN_WT: begin
        if (stat_i.div_done) state_d = stat_i.ch_last ? ST_EMIT : ST_MEAN_GO;
      end
      ST_EMIT:    if (!stat_i.out_full) state_d = ST_ADV;
      ST_ADV: begin
        if (stat_i.need_rbe) state_d = ST_RBE_GO;
        else if (stat_i.need_cbe) state_d = ST_CBE_GO;
        else state_d = ST_IDLE;
      end
      ST_RBE_GO:  state_d = ST_RBE_WT;
      ST_RBE_WT:  if (stat_i.div_done) state_d = ST_IDLE;
      ST_CBE_GO:  state_d = ST_CBE_WT;
      ST_CBE_WT:  if (stat_i.div_done) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      ST_IDLE:    if (in_valid_i) cmd_o = CMD_LATCH;
      ST_GEO_DIR: cmd_o = CMD_GEO_DIRECT;
      ST_OW_GO:   cmd_o = CMD_DIV_OW;
      ST_OW_WT:   if (stat_i.div_done) cmd_o = CMD_SET_OW;
      ST_OH_GO:   cmd_o = CMD_DIV_OH;
      ST_OH_WT:   if (stat_i.div_done) cmd_o = CMD_SET_OH;
      ST_WRAP:    cmd_o = CMD_WRAP;
      ST_FRAME:   if (stat_i.col_zero) cmd_o = CMD_DIV_CBE0;
      ST_CBE0_WT: if (stat_i.div_done) cmd_o = CMD_SET_CBE0;
      ST_RBE0_GO: cmd_o = CMD_DIV_RBE0;
      ST_RBE0_WT: if (stat_i.div_done) cmd_o = CMD_SET_RBE0;
      ST_READ:    cmd_o = CMD_READ;
      ST_ACC:     cmd_o = CMD_ACC;
      ST_MEAN_GO: cmd_o = CMD_DIV_MEAN;
      ST_MEAN_WT: if (stat_i.div_done) cmd_o = CMD_SET_MEAN;
      ST_EMIT:    if (!stat_i.out_full) cmd_o = CMD_EMIT;
      ST_ADV:     cmd_o = CMD_ADVANCE;
      ST_RBE_GO:  cmd_o = CMD_DIV_RBE;
      ST_RBE_WT:  if (stat_i.div_done) cmd_o = CMD_SET_RBE;
      ST_CBE_GO:  cmd_o = CMD_DIV_CBE;
      ST_CBE_WT:  if (stat_i.div_done) cmd_o = CMD_SET_CBE;
      default:    cmd_o = CMD_NONE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

>>> rtl/core/aad_dp.sv
// ----------------------------------------------------------------------------
// aad_dp
// Datapath: configuration, position counters, column sum memory, divider,
// output register.
// ----------------------------------------------------------------------------
module aad_dp #(
  parameter int unsigned MAX_WIDTH  = aad_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = aad_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [aad_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [aad_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic [aad_pkg::PIX_W-1:0]      in_red_i,
  input  logic [aad_pkg::PIX_W-1:0]      in_green_i,
  input  logic [aad_pkg::PIX_W-1:0]      in_blue_i,
  input  logic [aad_pkg::PIX_W-1:0]      in_alpha_i,
  input  aad_pkg::aad_cmd_e              cmd_i,
  output aad_pkg::aad_status_t           stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [aad_pkg::PIX_W-1:0]      out_red_o,
  output logic [aad_pkg::PIX_W-1:0]      out_green_o,
  output logic [aad_pkg::PIX_W-1:0]      out_blue_o,
  output logic [aad_pkg::PIX_W-1:0]      out_alpha_o,
  output logic                           frame_last_o,
  output logic [aad_pkg::CFG_W-1:0]      result_width_o,
  output logic [aad_pkg::CFG_W-1:0]      result_height_o
);
  import aad_pkg::*;

  localparam int unsigned DW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned LW    = (DW > HW) ? DW : HW;
  localparam int unsigned DEN_W = DW + HW;
  localparam int unsigned CHI_W = $clog2(CH_N);

  typedef logic [CH_N-1:0][SUM_W-1:0] sums_t;

  // Configuration and geometry
  logic [CFG_W-1:0] src_w_q, src_h_q, max_edge_q;
  logic [DW-1:0]    w_c, ow_q;
  logic [HW-1:0]    h_c, oh_q;
  logic [LW-1:0]    longest;
  logic             geo_valid_q;

  // Position
  logic [DW-1:0] col_q, oc_q, cbs_q, cbe_q, col1;
  logic [HW-1:0] row_q, orow_q, rbs_q, rbe_q, row1;
  logic          wrap;

  // Pixel, sums, means
  logic [CH_N-1:0][PIX_W-1:0] pix_q, mean_q;
  sums_t                      rd_q, acc_q, acc_d;
  logic [DEN_W-1:0]           count_q, count_c;
  logic [CHI_W-1:0]           ch_q;
  logic                       first;
  sums_t                      mem [MAX_WIDTH];

  // Divider
  logic             div_start, div_busy, div_done;
  logic [SUM_W-1:0] div_num, div_q;
  logic [DEN_W-1:0] div_den;

  // Output register
  logic                       out_valid_q, out_last_q;
  logic [CH_N-1:0][PIX_W-1:0] out_pix_q;
  logic [CFG_W-1:0]           out_w_q, out_h_q;

  // Clamped source size
  always_comb begin
    if (src_w_q == '0) w_c = DW'(1);
    else if (32'(src_w_q) > 32'(MAX_WIDTH)) w_c = DW'(MAX_WIDTH);
    else w_c = DW'(src_w_q);
    if (src_h_q == '0) h_c = HW'(1);
    else if (32'(src_h_q) > 32'(MAX_HEIGHT)) h_c = HW'(MAX_HEIGHT);
    else h_c = HW'(src_h_q);
    longest = (LW'(w_c) > LW'(h_c)) ? LW'(w_c) : LW'(h_c);
  end

  // Step look-ahead
  always_comb begin
    col1  = col_q + 1'b1;
    row1  = row_q + 1'b1;
    wrap  = (col1 >= w_c);
    first = (row_q == rbs_q) && (col_q == cbs_q);
    for (int c = 0; c < CH_N; c++) begin
      acc_d[c] = first ? SUM_W'(pix_q[c]) : rd_q[c] + SUM_W'(pix_q[c]);
    end
    count_c = DEN_W'(cbe_q - cbs_q) * DEN_W'(rbe_q - rbs_q);
    if (count_c == '0) count_c = DEN_W'(1);
  end

  // Divider operands
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = DEN_W'(1);
    case (cmd_i)
      CMD_DIV_OW: begin
        div_num = SUM_W'(w_c) * SUM_W'(max_edge_q);
        div_den = DEN_W'(longest);
      end
      CMD_DIV_OH: begin
        div_num = SUM_W'(h_c) * SUM_W'(max_edge_q);
        div_den = DEN_W'(longest);
      end
      CMD_DIV_CBE0: begin
        div_num = SUM_W'(w_c);
        div_den = DEN_W'(ow_q);
      end
      CMD_DIV_RBE0: begin
        div_num = SUM_W'(h_c);
        div_den = DEN_W'(oh_q);
      end
      CMD_DIV_CBE: begin
        div_num = SUM_W'(oc_q + 1'b1) * SUM_W'(w_c);
        div_den = DEN_W'(ow_q);
      end
      CMD_DIV_RBE: begin
        div_num = SUM_W'(orow_q + 1'b1) * SUM_W'(h_c);
        div_den = DEN_W'(oh_q);
      end
      CMD_DIV_MEAN: begin
        div_num = acc_q[ch_q];
        div_den = count_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  aad_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // Configuration, geometry and position control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= CFG_W'(1);
      src_h_q     <= CFG_W'(1);
      max_edge_q  <= CFG_W'(512);
      geo_valid_q <= 1'b0;
      ow_q        <= DW'(1);
      oh_q        <= HW'(1);
      col_q       <= '0;
      row_q       <= '0;
      oc_q        <= '0;
      orow_q      <= '0;
      cbs_q       <= '0;
      cbe_q       <= '0;
      rbs_q       <= '0;
      rbe_q       <= '0;
      ch_q        <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_SRC_WIDTH || cfg_addr_i == REG_SRC_HEIGHT ||
          cfg_addr_i == REG_MAX_EDGE) begin
        if (cfg_addr_i == REG_SRC_WIDTH)  src_w_q    <= cfg_wdata_i;
        if (cfg_addr_i == REG_SRC_HEIGHT) src_h_q    <= cfg_wdata_i;
        if (cfg_addr_i == REG_MAX_EDGE)   max_edge_q <= cfg_wdata_i;
        geo_valid_q <= 1'b0;
        col_q  <= '0;
        row_q  <= '0;
        oc_q   <= '0;
        orow_q <= '0;
        cbe_q  <= '0;
        rbs_q  <= '0;
        rbe_q  <= '0;
      end
    end else begin
      case (cmd_i)
        CMD_GEO_DIRECT: begin
          ow_q        <= w_c;
          oh_q        <= h_c;
          geo_valid_q <= 1'b1;
        end
        CMD_SET_OW: ow_q <= (div_q == '0) ? DW'(1) : div_q[DW-1:0];
        CMD_SET_OH: begin
          oh_q        <= (div_q == '0) ? HW'(1) : div_q[HW-1:0];
          geo_valid_q <= 1'b1;
        end
        CMD_WRAP: begin
          if (col_q >= w_c || row_q >= h_c) begin
            col_q <= '0;
            row_q <= '0;
          end
        end
        CMD_SET_CBE0: begin
          oc_q  <= '0;
          cbs_q <= '0;
          cbe_q <= div_q[DW-1:0];
        end
        CMD_SET_RBE0: begin
          orow_q <= '0;
          rbs_q  <= '0;
          rbe_q  <= div_q[HW-1:0];
        end
        CMD_ACC:      ch_q <= '0;
        CMD_SET_MEAN: ch_q <= ch_q + 1'b1;
        CMD_ADVANCE: begin
          if (wrap) begin
            col_q <= '0;
            row_q <= (row1 >= h_c) ? '0 : row1;
            if (row1 >= rbe_q) begin
              orow_q <= orow_q + 1'b1;
              rbs_q  <= rbe_q;
            end
          end else begin
            col_q <= col1;
            if (col1 == cbe_q) begin
              oc_q  <= oc_q + 1'b1;
              cbs_q <= cbe_q;
            end
          end
        end
        CMD_SET_RBE: rbe_q <= div_q[HW-1:0];
        CMD_SET_CBE: cbe_q <= div_q[DW-1:0];
        default: ;
      endcase
    end
  end

  // Pixel, sums and means
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LATCH) pix_q <= {in_alpha_i, in_blue_i, in_green_i, in_red_i};
    if (cmd_i == CMD_ACC) begin
      acc_q   <= acc_d;
      count_q <= count_c;
    end
    if (cmd_i == CMD_SET_MEAN) mean_q[ch_q] <= div_q[PIX_W-1:0];
  end

  // Column sum memory
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_READ) rd_q <= mem[oc_q[AW-1:0]];
    if (cmd_i == CMD_ACC)  mem[oc_q[AW-1:0]] <= acc_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_EMIT) begin
      out_pix_q  <= mean_q;
      out_last_q <= (oc_q + 1'b1 == ow_q) && (orow_q + 1'b1 == oh_q);
      out_w_q    <= CFG_W'(32'(ow_q));
      out_h_q    <= CFG_W'(32'(oh_q));
    end
  end

  // Status
  always_comb begin
    stat_o.geo_valid = geo_valid_q;
    stat_o.pass_thru = (32'(longest) <= 32'(max_edge_q));
    stat_o.col_zero  = (col_q == '0);
    stat_o.row_zero  = (row_q == '0);
    stat_o.box_done  = (col1 == cbe_q) && (row1 == rbe_q);
    stat_o.ch_last   = (ch_q == CHI_W'(CH_N - 1));
    stat_o.out_full  = out_valid_q;
    stat_o.need_rbe  = wrap && (row1 >= rbe_q);
    stat_o.need_cbe  = !wrap && (col1 == cbe_q);
    stat_o.div_done  = div_done;
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_pix_q[0];
  assign out_green_o     = out_pix_q[1];
  assign out_blue_o      = out_pix_q[2];
  assign out_alpha_o     = out_pix_q[3];
  assign frame_last_o    = out_last_q;
  assign result_width_o  = out_w_q;
  assign result_height_o = out_h_q;

  // Checks
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_emit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_EMIT) |-> !out_valid_q) else $error("output register overwritten");
  a_cfg_invalidates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_addr_i == REG_MAX_EDGE) |=> !geo_valid_q)
    else $error("geometry kept after configuration write");

endmodule

>>> rtl/core/area_average_downscale_top.sv
// ----------------------------------------------------------------------------
// area_average_downscale_top
// Streaming RGBA area-average downscaler with box-mean output.
// ----------------------------------------------------------------------------
// One source pixel is handled at a time through a shared 32-step bit-serial
// divider. A pixel that completes no box and crosses no box edge needs no
// division. Crossing a column or row box edge adds one for the next edge
// position. The first pixel of a row adds one (and one more at the start of a
// frame). A completed box adds one for each of the four channel means. The
// first pixel after a configuration write adds a width and a height division
// to size the output, none on pass-through. A result sits in an output
// register, so the next pixel is taken while it waits.
// ----------------------------------------------------------------------------
module area_average_downscale_top #(
  parameter int unsigned MAX_WIDTH  = aad_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = aad_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aad_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [aad_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [aad_pkg::PIX_W-1:0]     in_red_i,
  input  logic [aad_pkg::PIX_W-1:0]     in_green_i,
  input  logic [aad_pkg::PIX_W-1:0]     in_blue_i,
  input  logic [aad_pkg::PIX_W-1:0]     in_alpha_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [aad_pkg::PIX_W-1:0]     out_red_o,
  output logic [aad_pkg::PIX_W-1:0]     out_green_o,
  output logic [aad_pkg::PIX_W-1:0]     out_blue_o,
  output logic [aad_pkg::PIX_W-1:0]     out_alpha_o,
  output logic                          frame_last_o,
  output logic [aad_pkg::CFG_W-1:0]     result_width_o,
  output logic [aad_pkg::CFG_W-1:0]     result_height_o
);
  import aad_pkg::*;

  aad_cmd_e    cmd;
  aad_status_t stat;

  // Sequencer
  aad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath
  aad_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_red_i        (in_red_i),
    .in_green_i      (in_green_i),
    .in_blue_i       (in_blue_i),
    .in_alpha_i      (in_alpha_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .out_alpha_o     (out_alpha_o),
    .frame_last_o    (frame_last_o),
    .result_width_o  (result_width_o),
    .result_height_o (result_height_o)
  );

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for area_average_downscale_top: random RGBA frames over
// many source sizes and edge limits, with box means predicted and compared.
// ----------------------------------------------------------------------------
module testbench;
  import aad_pkg::*;

  localparam int unsigned WATCH_LIMIT = 6000;  // cycles with no transaction
  localparam int unsigned SETTLE      = 400;   // drain before a register write
  localparam int unsigned QUIET_TAIL  = 150;   // no idling over the last items

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic [PIX_W-1:0]     ch [CH_N];
  } stim_t;

  typedef struct {
    logic [PIX_W-1:0] ch [CH_N];
    logic             last;
    logic [CFG_W-1:0] rw;
    logic [CFG_W-1:0] rh;
  } box_mean_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = REG_SRC_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PIX_W-1:0]     in_red_i = '0, in_green_i = '0, in_blue_i = '0, in_alpha_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic                 frame_last_o;
  logic [CFG_W-1:0]     result_width_o, result_height_o;

  area_average_downscale_top u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pending stimulus and expected box means
  stim_t     pixel_q [$];
  box_mean_t mean_q [$];
  int unsigned err_cnt = 0, pix_cnt = 0, res_cnt = 0, cfg_cnt = 0;

  // Predictor state
  logic [CFG_W-1:0] p_w = 13'd1, p_h = 13'd1, p_me = 13'd512;
  logic [31:0] col_sum [CH_N][DEF_MAX_WIDTH];
  int unsigned s_col = 0, s_row = 0, o_col = 0, o_row = 0;
  int unsigned cbe = 0, rbs = 0, rbe = 0;

  function automatic int unsigned box_edge(int unsigned i, int unsigned src, int unsigned od);
    return int'((longint'(i) * longint'(src)) / longint'(od));
  endfunction

  function automatic void restart_frame();
    s_col = 0; s_row = 0; o_col = 0; o_row = 0; cbe = 0; rbs = 0; rbe = 0;
  endfunction

  // Accumulate one source pixel; push a mean when its box closes
  function automatic void predict_pixel(logic [PIX_W-1:0] ch [CH_N]);
    int unsigned w, h, ow, oh, lng, x0, oc;
    longint cnt;
    bit first;
    box_mean_t m;
    w = (p_w == 0) ? 1 : (p_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : p_w;
    h = (p_h == 0) ? 1 : (p_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : p_h;
    lng = (w > h) ? w : h;
    if (lng <= p_me) begin
      ow = w; oh = h;
    end else begin
      ow = box_edge(w, p_me, lng);
      oh = box_edge(h, p_me, lng);
      if (ow == 0) ow = 1;
      if (oh == 0) oh = 1;
    end
    if (s_col >= w || s_row >= h) begin
      s_col = 0; s_row = 0;
    end
    if (s_col == 0) begin
      o_col = 0; cbe = box_edge(1, w, ow);
    end
    if (s_col == 0 && s_row == 0) begin
      o_row = 0; rbs = 0; rbe = box_edge(1, h, oh);
    end
    oc = o_col;
    x0 = box_edge(oc, w, ow);
    first = (s_row == rbs) && (s_col == x0);
    for (int c = 0; c < CH_N; c++)
      col_sum[c][oc] = first ? 32'(ch[c]) : col_sum[c][oc] + 32'(ch[c]);
    if (s_col + 1 == cbe && s_row + 1 == rbe) begin
      cnt = longint'(cbe - x0) * longint'(rbe - rbs);
      if (cnt == 0) cnt = 1;
      for (int c = 0; c < CH_N; c++)
        m.ch[c] = 8'((longint'(col_sum[c][oc]) / cnt) & 255);
      m.last = (oc + 1 == ow) && (o_row + 1 == oh);
      m.rw = CFG_W'(ow);
      m.rh = CFG_W'(oh);
      mean_q.push_back(m);
    end
    s_col++;
    if (s_col >= w) begin
      s_col = 0;
      s_row++;
      if (s_row >= rbe) begin
        o_row++; rbs = rbe; rbe = box_edge(o_row + 1, h, oh);
      end
      if (s_row >= h) s_row = 0;
    end else if (s_col == cbe) begin
      o_col++; cbe = box_edge(o_col + 1, w, ow);
    end
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    stim_t s;
    s.is_cfg = 1'b1; s.idx = idx; s.val = CFG_W'(v);
    pixel_q.push_back(s);
  endfunction

  function automatic void add_geometry(int unsigned w, int unsigned h, int unsigned me);
    add_cfg(REG_SRC_WIDTH, w);
    add_cfg(REG_SRC_HEIGHT, h);
    add_cfg(REG_MAX_EDGE, me);
  endfunction

  function automatic void add_pixel(int unsigned r, int unsigned g, int unsigned b,
                                    int unsigned a);
    stim_t s;
    s.is_cfg = 1'b0; s.idx = REG_SRC_WIDTH; s.val = '0;
    s.ch[0] = 8'(r); s.ch[1] = 8'(g); s.ch[2] = 8'(b); s.ch[3] = 8'(a);
    pixel_q.push_back(s);
  endfunction

  function automatic void add_random_pixels(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
  endfunction

  // Driver: presents pixels, writes registers once the block has drained
  int unsigned gap = 0, settle = 0;
  logic [PIX_W-1:0] cur_ch [CH_N];
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv, nwe;
    stim_t s;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
    end else begin
      nv  = in_valid_i;
      nwe = 1'b0;
      if (in_valid_i && in_ready_o) begin
        predict_pixel(cur_ch);
        pix_cnt++;
        nv = 1'b0;
        settle = 0;
        if (pixel_q.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          gap = $urandom_range(1, 8);
      end
      if (mean_q.size() != 0 || (out_valid_o && out_ready_i)) settle = 0;
      if (!nv && pixel_q.size() != 0) begin
        if (gap != 0) begin
          gap--;
        end else if (pixel_q[0].is_cfg) begin
          if (mean_q.size() == 0 && settle >= SETTLE) begin
            s = pixel_q.pop_front();
            nwe = 1'b1;
            cfg_addr_i  <= s.idx;
            cfg_wdata_i <= s.val;
            case (s.idx)
              REG_SRC_WIDTH:  p_w = s.val;
              REG_SRC_HEIGHT: p_h = s.val;
              default:        p_me = s.val;
            endcase
            restart_frame();
            cfg_cnt++;
          end else begin
            settle++;
          end
        end else begin
          s = pixel_q.pop_front();
          cur_ch = s.ch;
          in_red_i   <= s.ch[0];
          in_green_i <= s.ch[1];
          in_blue_i  <= s.ch[2];
          in_alpha_i <= s.ch[3];
          nv = 1'b1;
        end
      end
      in_valid_i <= nv;
      cfg_we_i   <= nwe;
    end
  end

  // Monitor: random back-pressure and comparison against the oldest mean
  int unsigned stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    box_mean_t m;
    logic [PIX_W-1:0] got [CH_N];
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        res_cnt++;
        got[0] = out_red_o; got[1] = out_green_o; got[2] = out_blue_o; got[3] = out_alpha_o;
        if (mean_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 40) $display("%0t: unexpected result transaction", $time);
        end else begin
          m = mean_q.pop_front();
          for (int c = 0; c < CH_N; c++)
            if (got[c] !== m.ch[c]) begin
              err_cnt++;
              if (err_cnt <= 40)
                $display("%0t: channel %0d expected %0d actual %0d", $time, c, m.ch[c], got[c]);
            end
          if (frame_last_o !== m.last) begin
            err_cnt++;
            if (err_cnt <= 40)
              $display("%0t: frame_last expected %0b actual %0b", $time, m.last, frame_last_o);
          end
          if (result_width_o !== m.rw || result_height_o !== m.rh) begin
            err_cnt++;
            if (err_cnt <= 40)
              $display("%0t: size expected %0dx%0d actual %0dx%0d", $time, m.rw, m.rh,
                       result_width_o, result_height_o);
          end
        end
      end
      if (stall != 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (pixel_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles = 0;
    else if (++quiet_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus plan and end of run
  initial begin
    int unsigned w, h, me, frames, total, n;
    // pass-through with channel extremes
    add_geometry(2, 2, 512);
    add_pixel(0, 0, 0, 0); add_pixel(255, 255, 255, 255);
    add_pixel(8'h55, 8'hAA, 8'h55, 8'hAA); add_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    // 2x2 boxes, all-white box then all-black
    add_geometry(4, 4, 2);
    for (int i = 0; i < 16; i++) begin
      if (i % 4 < 2 && i < 8) add_pixel(255, 255, 255, 255);
      else if (i % 4 >= 2 && i < 8) add_pixel(0, 0, 0, 0);
      else add_pixel(i * 16, 255 - i * 16, i, 200);
    end
    // zero width is one column, zero edge gives a single pixel
    add_geometry(0, 3, 0);
    add_random_pixels(3);
    // oversize registers saturate; partial frame dropped by the next write
    add_geometry(8191, 1, 8191);
    add_random_pixels(4);
    add_geometry(4096, 4096, 4096);
    add_random_pixels(3);
    total = 30;
    // random geometries, mostly complete frames; wide rows only early on
    while (total < 1850) begin
      if (total < 1200 && $urandom_range(0, 9) == 0) begin
        w = $urandom_range(100, 600); h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 12); h = $urandom_range(1, 12);
      end
      me = $urandom_range(0, 4) == 0 ? $urandom_range(13, 8191) : $urandom_range(0, 12);
      add_geometry(w, h, me);
      frames = $urandom_range(1, 2);
      for (int unsigned f = 0; f < frames; f++) begin
        if ($urandom_range(0, 7) == 0) begin
          n = $urandom_range(1, w * h);
          add_random_pixels(n);  // broken frame
          total += n;
          break;
        end
        add_random_pixels(w * h);
        total += w * h;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pixel_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d source pixels and %0d register writes, %0d box means checked.",
             pix_cnt, cfg_cnt, res_cnt);
    $display("Geometries ran from single-pixel results to pass-through, %0d mismatches.",
             err_cnt);
    if (err_cnt == 0 && mean_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
